### src/aarm_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared constants, the arctangent table and the CORDIC cell payload type.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int FRAC_BITS         = 14;
    localparam int ATAN_COUNT        = 24;
    localparam int NUM_STAGES        = (CORDIC_ITERATIONS < ATAN_COUNT) ?
                                       CORDIC_ITERATIONS : ATAN_COUNT;

    // CORDIC datapath width: Q.30 values stay below 2^32 in magnitude.
    localparam int CW = 34;

    localparam logic signed [CW-1:0] ONE_Q30     = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
    localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);
    localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
        logic signed [15:0]   ax;
        logic signed [15:0]   ay;
        logic signed [15:0]   az;
    } cell_data_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return CW'($signed({1'b0, v}));
    endfunction

endpackage

### src/aarm_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step of the CORDIC chain; registers its result when enabled.
// ----------------------------------------------------------------------------
module aarm_cordic_cell (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [4:0]              step,
    input  aarm_pkg::cell_data_t    din,
    output aarm_pkg::cell_data_t    dout
);
    import aarm_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    always_comb begin
        dx = din.y >>> step;
        dy = din.x >>> step;
        at = atan_q30(step);
        data_next = din;
        if (!din.z[CW-1]) begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - at;
        end else begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;
endmodule

### src/aarm_matrix_calc.sv
// ----------------------------------------------------------------------------
// Matrix back end
// Turns cosine, sine and the axis into the nine saturated matrix entries
// over three registered stages.
// ----------------------------------------------------------------------------
module aarm_matrix_calc (
    input  logic                  aclk,
    input  logic [2:0]            en,
    input  aarm_pkg::cell_data_t  din,
    output logic signed [15:0]    m_out [9]
);
    import aarm_pkg::*;

    localparam int PW = 2 * 16 + CW;
    // Quadratic terms reach about 2^33 for full-scale axes, and the sums go
    // beyond that before saturation.
    localparam int SW = CW + 2;

    // Stage 1: cosine, sine, one minus cosine, axis products.
    logic signed [CW-1:0] c_reg, s_reg, omc_reg;
    logic signed [31:0]   pp_reg [6];
    logic signed [15:0]   a1_reg [3];
    // Stage 2: quadratic and sine terms.
    logic signed [SW-1:0] q_reg [6];
    logic signed [SW-1:0] t_reg [3];
    logic signed [SW-1:0] c2_reg;
    // Stage 3: output registers.
    logic signed [15:0]   m_reg [9];

    logic signed [CW-1:0] c_next, s_next;
    logic signed [SW-1:0] sum [9];

    always_comb begin
        c_next = din.flip ? -din.x : din.x;
        s_next = din.flip ? -din.y : din.y;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            omc_reg   <= ONE_Q30 - c_next;
            pp_reg[0] <= din.ax * din.ax;
            pp_reg[1] <= din.ay * din.ay;
            pp_reg[2] <= din.az * din.az;
            pp_reg[3] <= din.ax * din.ay;
            pp_reg[4] <= din.ax * din.az;
            pp_reg[5] <= din.ay * din.az;
            a1_reg[0] <= din.ax;
            a1_reg[1] <= din.ay;
            a1_reg[2] <= din.az;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 6; i++) begin
                q_reg[i] <= SW'((PW'(pp_reg[i]) * PW'(omc_reg)
                                 + (PW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS));
            end
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= SW'(((CW + 16)'(a1_reg[i]) * (CW + 16)'(s_reg)
                                 + ((CW + 16)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            end
            c2_reg <= SW'(c_reg);
        end
    end

    function automatic logic signed [15:0] finish(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > SW'(32767)) return 16'sh7FFF;
        if (r < -SW'(32768)) return 16'sh8000;
        return r[15:0];
    endfunction

    always_comb begin
        sum[0] = q_reg[0] + c2_reg;
        sum[1] = q_reg[3] + t_reg[2];
        sum[2] = q_reg[4] - t_reg[1];
        sum[3] = q_reg[3] - t_reg[2];
        sum[4] = q_reg[1] + c2_reg;
        sum[5] = q_reg[5] + t_reg[0];
        sum[6] = q_reg[4] + t_reg[1];
        sum[7] = q_reg[5] - t_reg[0];
        sum[8] = q_reg[2] + c2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 9; i++) begin
                m_reg[i] <= finish(sum[i]);
            end
        end
    end

    assign m_out = m_reg;
endmodule

### src/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix
// Rodrigues rotation matrix from an angle and a unit axis via CORDIC.
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle unless stalled, and returns
// the matrix through one fold stage, one CORDIC cell per iteration, and
// three back-end stages.
// The whole pipeline stalls when the output transaction is not taken.
module axis_angle_rotation_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_angle,
    input  logic signed [15:0] s_axis_x,
    input  logic signed [15:0] s_axis_y,
    input  logic signed [15:0] s_axis_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_m00,
    output logic signed [15:0] m_m10,
    output logic signed [15:0] m_m20,
    output logic signed [15:0] m_m01,
    output logic signed [15:0] m_m11,
    output logic signed [15:0] m_m21,
    output logic signed [15:0] m_m02,
    output logic signed [15:0] m_m12,
    output logic signed [15:0] m_m22
);
    import aarm_pkg::*;

    localparam int DEPTH = NUM_STAGES + 4;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             adv;
    logic [DEPTH-1:0] en;
    cell_data_t       fold_reg;
    cell_data_t       fold_next;
    cell_data_t       chain [NUM_STAGES+1];
    logic signed [CW-1:0] t;
    logic signed [15:0]   m_out [9];

    // All stages advance together whenever the last stage is empty or taken.
    always_comb begin
        adv = m_ready || !vld_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++) begin
            en[i] = adv;
        end
        vld_next = adv ? {vld_reg[DEPTH-2:0], s_valid} : vld_reg;
    end

    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        t = CW'(s_angle) <<< 17;
        fold_next.flip = 1'b0;
        if (t > HALF_PI_Q30) begin
            t = t - PI_Q30;
            fold_next.flip = 1'b1;
        end else if (t < -HALF_PI_Q30) begin
            t = t + PI_Q30;
            fold_next.flip = 1'b1;
        end
        fold_next.x  = GAIN_Q30;
        fold_next.y  = '0;
        fold_next.z  = t;
        fold_next.ax = s_axis_x;
        fold_next.ay = s_axis_y;
        fold_next.az = s_axis_z;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            fold_reg <= fold_next;
        end
    end

    assign chain[0] = fold_reg;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        aarm_cordic_cell u_cell (
            .aclk (aclk),
            .en   (en[g+1]),
            .step (5'(g)),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    aarm_matrix_calc u_calc (
        .aclk  (aclk),
        .en    (en[DEPTH-1:DEPTH-3]),
        .din   (chain[NUM_STAGES]),
        .m_out (m_out)
    );

    assign m_valid = vld_reg[DEPTH-1];
    assign m_m00 = m_out[0];
    assign m_m10 = m_out[1];
    assign m_m20 = m_out[2];
    assign m_m01 = m_out[3];
    assign m_m11 = m_out[4];
    assign m_m21 = m_out[5];
    assign m_m02 = m_out[6];
    assign m_m12 = m_out[7];
    assign m_m22 = m_out[8];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_m00) && $stable(m_m22))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid && m_valid && m_ready |=>
            $countones(vld_reg) == $countones($past(vld_reg)) - 1)
        else $error("transaction count mismatch");
endmodule

### verif/rotation_matrix_checker.sv
// ----------------------------------------------------------------------------
// Rotation matrix checker
// Watches both channels of the axis-angle rotation matrix block. It predicts
// each matrix from the accepted angle and axis, and compares the entries in
// order of arrival.
// ----------------------------------------------------------------------------
module rotation_matrix_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_angle,
    input  logic signed [15:0] s_axis_x,
    input  logic signed [15:0] s_axis_y,
    input  logic signed [15:0] s_axis_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_m00,
    input  logic signed [15:0] m_m10,
    input  logic signed [15:0] m_m20,
    input  logic signed [15:0] m_m01,
    input  logic signed [15:0] m_m11,
    input  logic signed [15:0] m_m21,
    input  logic signed [15:0] m_m02,
    input  logic signed [15:0] m_m12,
    input  logic signed [15:0] m_m22,
    output int                 mismatches,
    output int                 outstanding
);

    // Entries in port order: m00, m10, m20, m01, m11, m21, m02, m12, m22.
    typedef logic [8:0][15:0] matrix_t;

    localparam longint UNIT_Q30    = 64'sd1073741824;
    localparam longint PI_FIXED    = 64'sd3373259426;
    localparam longint HALF_PI_FIX = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam int     FB          = aarm_pkg::FRAC_BITS;

    localparam longint ARCTAN [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    localparam string ENTRY_NAME [9] = '{
        "m00", "m10", "m20", "m01", "m11", "m21", "m02", "m12", "m22"
    };

    matrix_t pending_matrices [$];
    int      error_count = 0;

    assign mismatches  = error_count;
    assign outstanding = pending_matrices.size();

    function automatic longint round_shift(longint v, int n);
        if (n == 0) return v;
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [15:0] to_entry(longint sum_q30);
        longint v;
        v = round_shift(sum_q30, 30 - FB);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic matrix_t rodrigues_matrix(logic signed [15:0] angle,
                                                 logic signed [15:0] ax16,
                                                 logic signed [15:0] ay16,
                                                 logic signed [15:0] az16);
        longint t, x, y, dx, dy, c, s, omc, ax, ay, az;
        longint pxx, pyy, pzz, pxy, pxz, pyz, qx, qy, qz;
        bit flip;
        matrix_t m;
        t = longint'(angle) * 131072;
        ax = ax16;
        ay = ay16;
        az = az16;
        flip = 1'b0;
        x = CORDIC_GAIN;
        y = 0;
        // Fold the angle into -pi/2 .. pi/2; a folded result is negated afterwards.
        if (t > HALF_PI_FIX) begin
            t = t - PI_FIXED;
            flip = 1'b1;
        end else if (t < -HALF_PI_FIX) begin
            t = t + PI_FIXED;
            flip = 1'b1;
        end
        for (int i = 0; i < aarm_pkg::NUM_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x = x - dx;
                y = y + dy;
                t = t - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                t = t + ARCTAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        omc = UNIT_Q30 - c;
        pxx = round_shift(ax * ax * omc, 2 * FB);
        pyy = round_shift(ay * ay * omc, 2 * FB);
        pzz = round_shift(az * az * omc, 2 * FB);
        pxy = round_shift(ax * ay * omc, 2 * FB);
        pxz = round_shift(ax * az * omc, 2 * FB);
        pyz = round_shift(ay * az * omc, 2 * FB);
        qx = round_shift(ax * s, FB);
        qy = round_shift(ay * s, FB);
        qz = round_shift(az * s, FB);
        m[0] = to_entry(pxx + c);
        m[1] = to_entry(pxy + qz);
        m[2] = to_entry(pxz - qy);
        m[3] = to_entry(pxy - qz);
        m[4] = to_entry(pyy + c);
        m[5] = to_entry(pyz + qx);
        m[6] = to_entry(pxz + qy);
        m[7] = to_entry(pyz - qx);
        m[8] = to_entry(pzz + c);
        return m;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge aclk) begin
        matrix_t got, want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_matrices.push_back(
                    rodrigues_matrix(s_angle, s_axis_x, s_axis_y, s_axis_z));
            end
            if (m_valid && m_ready) begin
                got = {m_m22, m_m12, m_m02, m_m21, m_m11, m_m01, m_m20, m_m10, m_m00};
                if (pending_matrices.size() == 0) begin
                    report_mismatch("matrix transaction with none expected");
                end else begin
                    want = pending_matrices.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k]) begin
                            report_mismatch($sformatf("%s got %0d expected %0d",
                                ENTRY_NAME[k], $signed(got[k]), $signed(want[k])));
                        end
                    end
                end
            end
        end
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix testbench
// Drives directed and random angle/axis transactions under varying idle
// patterns and a long output stall, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HALF_PI_Q13 = 12868;
    localparam int PI_Q13      = 25736;
    localparam int ONE_Q14     = 16384;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_angle = '0;
    logic signed [15:0] s_axis_x = '0;
    logic signed [15:0] s_axis_y = '0;
    logic signed [15:0] s_axis_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_m00, m_m10, m_m20, m_m01, m_m11, m_m21, m_m02, m_m12, m_m22;

    int mismatches;
    int outstanding;
    int sender_idle_pct = 15;
    int receiver_idle_pct = 79;
    int cycle_count = 0;
    logic stall_request = 1'b0;
    int   stall_left = 0;
    bit   stall_done = 1'b0;

    axis_angle_rotation_matrix DUT (.*);

    rotation_matrix_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("axis_angle_rotation_matrix regression: fail");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (stall_request && !stall_done && stall_left == 0) begin
            stall_left <= 300;
            stall_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Only the low 16 bits of each argument are driven.
    task automatic send_rotation(int angle, int ax, int ay, int az);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_angle <= 16'(angle);
        s_axis_x <= 16'(ax);
        s_axis_y <= 16'(ay);
        s_axis_z <= 16'(az);
        // s_ready is sampled mid-cycle, where it is stable up to the next edge.
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic send_random_rotation();
        int lim;
        if ($urandom_range(99) < 80) begin
            // Axes bounded per component by either 9459 or one unit (ONE_Q14).
            lim = $urandom_range(1) ? 9459 : ONE_Q14;
            send_rotation($urandom, $urandom_range(2 * lim) - lim,
                          $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim);
        end else begin
            send_rotation($urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: axis directions, angle extremes and the fold boundaries.
        send_rotation(0, ONE_Q14, 0, 0);
        send_rotation(16'sh7FFF, 0, ONE_Q14, 0);
        send_rotation(-16'sh8000, 0, 0, ONE_Q14);
        send_rotation(HALF_PI_Q13, ONE_Q14, 0, 0);
        send_rotation(HALF_PI_Q13 + 1, 0, ONE_Q14, 0);
        send_rotation(-HALF_PI_Q13, 0, 0, ONE_Q14);
        send_rotation(-HALF_PI_Q13 - 1, -ONE_Q14, 0, 0);
        send_rotation(PI_Q13, 0, -ONE_Q14, 0);
        send_rotation(-PI_Q13, 0, 0, -ONE_Q14);
        send_rotation(8579, 9459, 9459, 9459);
        send_rotation(-8579, -9459, 9459, -9459);
        send_rotation(1, 11585, -11585, 0);
        send_rotation(-1, 0, 11585, 11585);
        // Axes far from unit length drive the entries into saturation.
        send_rotation(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_rotation(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_rotation(PI_Q13, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
        send_rotation(HALF_PI_Q13, -16'sh8000, 16'sh7FFF, -16'sh8000);
        send_rotation(PI_Q13, -16'sh8000, -16'sh8000, -16'sh8000);
        send_rotation(4000, 0, 0, 0);

        repeat (300) send_random_rotation();
        sender_idle_pct = 79;
        receiver_idle_pct = 15;
        repeat (300) send_random_rotation();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        stall_request <= 1'b1;
        repeat (300) send_random_rotation();
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("axis_angle_rotation_matrix regression: pass");
        end else begin
            $display("axis_angle_rotation_matrix regression: fail");
        end
        $finish;
    end

endmodule
